// File: rtl/core/double_ended_queue_top_defines.svh
// assertion macros for the double ended queue checker
// no dependencies
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, disabled during reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// File: rtl/core/deq_pkg.sv
// shared constants, types and helper functions for the double ended queue
// no dependencies
package deq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = CNT_BITS + 1;
    localparam int OCC_BITS  = 5;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PTR_BITS-1:0]  ptr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
        logic build;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // ring position head + off, with off at most the depth
    function automatic ptr_t slot_add(input ptr_t head, input cnt_t off);
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(head) + SUM_BITS'(off);
        if (sum >= SUM_BITS'(DEPTH))
        begin
            sum = sum - SUM_BITS'(DEPTH);
        end
        return PTR_BITS'(sum);
    endfunction

    // sign extend the 32-bit request word and cut to the stored width
    function automatic word_t word_in(input logic [31:0] v);
        logic signed [31:0] vs;
        logic signed [63:0] wide;
        vs = v;
        wide = vs;
        return wide[WORD_BITS-1:0];
    endfunction

    // sign extend a stored word and cut to the 32-bit result field
    function automatic logic [31:0] word_out(input word_t w);
        logic signed [WORD_BITS-1:0] ws;
        logic signed [63:0] wide;
        ws = w;
        wide = ws;
        return wide[31:0];
    endfunction

endpackage

// File: rtl/core/double_ended_queue_top.sv
// top level of the double ended queue: controller plus datapath
// depends on deq_pkg, deq_ctrl, deq_dpath
//
// Bounded double-ended queue of DEPTH signed words held in a ring memory.
// Each request carries a command (push front, push back, pop front, pop back)
// and a word, and gives exactly one result: status, popped word, front and
// rear words after the request (all ones when empty), empty flag and count.
// After acceptance a request passes through execute, fetch and build until
// its result is loaded into the output register: execute does the memory
// write or pop read and moves the pointers, fetch reads the new front and
// rear entries, and build builds the result. The registered memory reads set
// this order, since the front and rear can only be read once the pointers have
// moved. No request is accepted before the last one is built. A result
// waiting in the output register does not stop the next request from being
// accepted and executed; only its build step waits for the output register.
module double_ended_queue_top
    import deq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // command[1:0], value[33:2], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // status, popped_value, front_value,
                                    // rear_value, is_empty, occupancy
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    deq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/core/deq_ctrl.sv
// sequencer for the double ended queue: accept, execute, fetch, build
// depends on deq_pkg
module deq_ctrl
    import deq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  ctrl_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_BUILD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ctrl_cmd       = '0;
        ctrl_cmd.load  = s_tvalid && s_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl_cmd.exec = 1'b1;
                state_next    = S_FETCH;
            end
            S_FETCH:
            begin
                ctrl_cmd.fetch = 1'b1;
                state_next     = S_BUILD;
            end
            S_BUILD:
            begin
                if (dp_status.out_free)
                begin
                    ctrl_cmd.build = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/deq_dpath.sv
// datapath for the double ended queue: ring memory, pointers, result register
// depends on deq_pkg
module deq_dpath
    import deq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    ctrl_cmd,
    output dp_status_t   dp_status,
    input  logic [39:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata
);

    word_t mem [DEPTH];

    logic [1:0]  cmd_reg;
    word_t       val_reg;
    ptr_t        head_reg;
    ptr_t        head_next;
    cnt_t        count_reg;
    cnt_t        count_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic        pop_ok_reg;
    logic        pop_ok_next;
    word_t       rd_a_reg;
    word_t       rd_b_reg;
    logic [31:0] popped_reg;
    logic        out_valid_reg;
    logic [103:0] out_reg;

    logic        empty;
    logic        full;
    logic        is_push;
    ptr_t        head_dec;
    ptr_t        head_inc;
    cnt_t        last_off;
    ptr_t        rear_addr;
    ptr_t        back_addr;
    ptr_t        rd_a_addr;
    logic        we;
    ptr_t        waddr;
    logic [31:0] front_word;
    logic [31:0] rear_word;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign is_push   = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_PUSH_BACK);
    assign head_dec  = (head_reg == '0) ? PTR_BITS'(DEPTH - 1) : head_reg - PTR_BITS'(1);
    assign head_inc  = (head_reg == PTR_BITS'(DEPTH - 1)) ? '0 : head_reg + PTR_BITS'(1);
    assign last_off  = empty ? '0 : count_reg - CNT_BITS'(1);
    assign rear_addr = slot_add(head_reg, last_off);
    assign back_addr = slot_add(head_reg, count_reg);
    assign rd_a_addr = (ctrl_cmd.exec && (cmd_reg == CMD_POP_BACK)) ? rear_addr : head_reg;

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        pop_ok_next = 1'b0;
        we          = 1'b0;
        waddr       = back_addr;
        if (is_push)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                we         = 1'b1;
                count_next = count_reg + CNT_BITS'(1);
                if (cmd_reg == CMD_PUSH_FRONT)
                begin
                    waddr     = head_dec;
                    head_next = head_dec;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                pop_ok_next = 1'b1;
                count_next  = count_reg - CNT_BITS'(1);
                if (cmd_reg == CMD_POP_FRONT)
                begin
                    head_next = head_inc;
                end
            end
        end
    end

    // ring memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.exec && we)
        begin
            mem[waddr] <= val_reg;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rear_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl_cmd.exec)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (ctrl_cmd.build)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign front_word = empty ? '1 : word_out(rd_a_reg);
    assign rear_word  = empty ? '1 : word_out(rd_b_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            cmd_reg <= s_tdata[1:0];
            val_reg <= word_in(s_tdata[33:2]);
        end
        if (ctrl_cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
        if (ctrl_cmd.fetch)
        begin
            popped_reg <= pop_ok_reg ? word_out(rd_a_reg) : '0;
        end
        if (ctrl_cmd.build)
        begin
            out_reg <= {OCC_BITS'(count_reg), empty, rear_word, front_word,
                        popped_reg, status_reg};
        end
    end

    assign dp_status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// File: rtl/core/deq_checker.sv
// port-level assertions for the double ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue_top_defines.svh
`include "double_ended_queue_top_defines.svh"

module deq_checker
    import deq_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [39:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    `DEQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `DEQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `DEQ_ASSERT_NOW(a_empty_flag, clk, rst_n, m_tvalid, m_tdata[98] == (m_tdata[103:99] == '0))
    `DEQ_ASSERT_NOW(a_empty_ends, clk, rst_n, m_tvalid && m_tdata[98], (m_tdata[65:34] == '1) && (m_tdata[97:66] == '1))
    `DEQ_ASSERT_NOW(a_no_pop_word, clk, rst_n, m_tvalid && (m_tdata[1:0] != ST_DONE), m_tdata[33:2] == '0)

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);
